// ----- sv/fhlc_pkg.sv -----
`timescale 1ns / 1ps

package fhlc_pkg;

  localparam int CACHE_SLOTS = 8;
  localparam int IDX_W       = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int SLOT_W      = 3;
  localparam int FONT_W      = 10;
  localparam int SIZE_W      = 16;
  localparam int HANDLE_W    = 8;
  localparam int STAMP_W     = 32;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fhlc_state_t;

  // Only the low three bits of a slot index are reported.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// ----- sv/font_handle_lru_cache_top.sv -----
`timescale 1ns / 1ps

// Channel  Handshake                     Fields
// in       in_valid / in_stall (out)     mode, font_id, point_size, new_handle
// out      out_valid / out_stall (in)    hit, handle, slot, evicted, evicted_handle
//
// A request is captured in ST_IDLE, then ST_SCAN visits the slots in turn, and
// ST_DONE moves the result to the output register once the output is free.
// The scan reads one slot per cycle through a single age subtractor and compare.
// A lookup stops at the first hit; an insert stops at the first empty slot.
// Reset clears the valid bits, the use clock and the output valid; no sweep is needed.
// A stalled output holds the finished word, and the next request waits behind it.

module font_handle_lru_cache_top
  import fhlc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [FONT_W-1:0]   font_id,
  input  logic [SIZE_W-1:0]   point_size,
  input  logic [HANDLE_W-1:0] new_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hit,
  output logic [HANDLE_W-1:0] handle,
  output logic [SLOT_W-1:0]   slot,
  output logic                evicted,
  output logic [HANDLE_W-1:0] evicted_handle
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_SLOTS - 1);

  fhlc_state_t state, state_next;

  logic [CACHE_SLOTS-1:0] slot_valid;
  logic [FONT_W-1:0]      slot_font     [CACHE_SLOTS];
  logic [SIZE_W-1:0]      slot_size     [CACHE_SLOTS];
  logic [HANDLE_W-1:0]    slot_handle   [CACHE_SLOTS];
  logic [STAMP_W-1:0]     slot_last_use [CACHE_SLOTS];
  logic [STAMP_W-1:0]     use_clock;

  logic                req_mode;
  logic [FONT_W-1:0]   req_font;
  logic [SIZE_W-1:0]   req_size;
  logic [HANDLE_W-1:0] req_handle;

  logic [IDX_W-1:0]    idx;
  logic [STAMP_W-1:0]  oldest;
  logic [IDX_W-1:0]    victim;
  logic [HANDLE_W-1:0] victim_handle;

  logic                res_hit;
  logic [HANDLE_W-1:0] res_handle;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_evicted;
  logic [HANDLE_W-1:0] res_evicted_handle;

  logic                cur_valid;
  logic                cur_match;
  logic [STAMP_W-1:0]  cur_age;
  logic                take_cur;
  logic [IDX_W-1:0]    cand_victim;
  logic [HANDLE_W-1:0] cand_handle;
  logic [STAMP_W-1:0]  cand_age;
  logic                last_slot;
  logic                scan_done;
  logic                out_free;
  logic                accept_in;
  logic                scan_en;
  logic                load_out;

  // Shared scan datapath: one slot per cycle.
  always_comb begin
    cur_valid = slot_valid[idx];
    cur_match = cur_valid && (slot_font[idx] == req_font) && (slot_size[idx] == req_size);
    cur_age   = use_clock - slot_last_use[idx];
    // Slot 0 always seeds the search, which matches a strict compare against zero.
    take_cur  = (idx == '0) || (cur_age > oldest);
    cand_victim = take_cur ? idx : victim;
    cand_handle = take_cur ? slot_handle[idx] : victim_handle;
    cand_age    = take_cur ? cur_age : oldest;
    last_slot   = (idx == LAST_IDX);
    if (req_mode == MODE_INSERT) begin
      scan_done = !cur_valid || last_slot;
    end else begin
      scan_done = cur_match || last_slot;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (scan_done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    accept_in = 1'b0;
    scan_en   = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        accept_in = in_valid;
      end
      ST_SCAN: scan_en  = 1'b1;
      ST_DONE: load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      req_mode   <= mode;
      req_font   <= font_id;
      req_size   <= point_size;
      req_handle <= new_handle;
      idx        <= '0;
      oldest     <= '0;
      victim     <= '0;
    end else if (scan_en && !scan_done) begin
      idx           <= idx + 1'b1;
      oldest        <= cand_age;
      victim        <= cand_victim;
      victim_handle <= cand_handle;
    end
  end

  // Cache contents and result; only the valid bits and the use clock need reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      use_clock  <= '0;
    end else if (scan_en && scan_done) begin
      res_hit            <= 1'b0;
      res_handle         <= '0;
      res_slot           <= '0;
      res_evicted        <= 1'b0;
      res_evicted_handle <= '0;
      if (req_mode == MODE_LOOKUP) begin
        if (cur_match) begin
          res_hit            <= 1'b1;
          res_handle         <= slot_handle[idx];
          res_slot           <= slot_of(idx);
          slot_last_use[idx] <= use_clock;
          use_clock          <= use_clock + 1'b1;
        end
      end else if (!cur_valid) begin
        slot_valid[idx]    <= 1'b1;
        slot_font[idx]     <= req_font;
        slot_size[idx]     <= req_size;
        slot_handle[idx]   <= req_handle;
        slot_last_use[idx] <= use_clock;
        use_clock          <= use_clock + 1'b1;
        res_slot           <= slot_of(idx);
      end else begin
        // Every slot is full: replace the oldest one.
        slot_font[cand_victim]     <= req_font;
        slot_size[cand_victim]     <= req_size;
        slot_handle[cand_victim]   <= req_handle;
        slot_last_use[cand_victim] <= use_clock;
        use_clock                  <= use_clock + 1'b1;
        res_slot                   <= slot_of(cand_victim);
        res_evicted                <= 1'b1;
        res_evicted_handle         <= cand_handle;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit            <= res_hit;
      handle         <= res_handle;
      slot           <= res_slot;
      evicted        <= res_evicted;
      evicted_handle <= res_evicted_handle;
    end
  end

endmodule
